// ===== rtl/tmps_pkg.sv =====
`timescale 1ns / 1ps

package tmps_pkg;

	// Default sizing of the row buffer and of one triangle entry.
	localparam int MAX_ROWS_DEF    = 128;
	localparam int VALUE_WIDTH_DEF = 16;

	// Fixed widths of the configuration register and of the result.
	localparam int ROW_COUNT_W = 8;
	localparam int OUT_WIDTH   = 23;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;

	// Classification of one entry, worked out by the front part.
	typedef struct packed {
		logic has_up;    // the row above holds a sum in this column
		logic has_left;  // the row above holds a sum in the column to the left
		logic last_row;  // the entry belongs to the bottom row
		logic end_row;   // the entry closes its row
	} item_flags_t;

endpackage

// ===== rtl/tmps_front.sv =====
`timescale 1ns / 1ps

module tmps_front #(
	parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
	parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF,
	parameter int IDX_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmps_pkg::ROW_COUNT_W-1:0]    row_count,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [VALUE_WIDTH-1:0]       value,
	input  logic                                q_full,
	output logic                                q_push,
	output logic signed [VALUE_WIDTH-1:0]       q_value,
	output logic [IDX_W-1:0]                    q_col,
	output tmps_pkg::item_flags_t               q_flags
);

	localparam int CMP_W = (IDX_W + 1 > tmps_pkg::ROW_COUNT_W) ? IDX_W + 1 :
		tmps_pkg::ROW_COUNT_W;

	logic [IDX_W-1:0] last_row_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] last_row_next;
	logic [CMP_W-1:0] rows_wide;
	logic             cfg_write;
	logic             accept;

	// The register is always able to take a write.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// Index of the bottom row: a count of zero means one row, and a count
	// beyond the row buffer is limited to its size.
	assign rows_wide = CMP_W'(row_count);
	always_comb begin
		if (rows_wide == '0) begin
			last_row_next = '0;
		end else if (rows_wide > CMP_W'(MAX_ROWS)) begin
			last_row_next = IDX_W'(MAX_ROWS - 1);
		end else begin
			last_row_next = IDX_W'(rows_wide - CMP_W'(1));
		end
	end

	// Entries are taken whenever the queue has room.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;
	assign q_value  = value;
	assign q_col    = col_q;

	// Classify the entry by its place in the triangle.
	always_comb begin
		q_flags.has_up   = col_q < row_q;
		q_flags.has_left = col_q != '0;
		q_flags.last_row = row_q == last_row_q;
		q_flags.end_row  = col_q == row_q;
	end

	// Row and column counters; a register write restarts the triangle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_write) begin
			last_row_q <= last_row_next;
			row_q      <= '0;
			col_q      <= '0;
		end else if (accept) begin
			if (q_flags.end_row) begin
				col_q <= '0;
				if (q_flags.last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + IDX_W'(1);
				end
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tmps_queue.sv =====
`timescale 1ns / 1ps

module tmps_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tmps_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = slot_q[rd_ptr_q];

	// Storage for queued requests.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tmps_back.sv =====
`timescale 1ns / 1ps

module tmps_back #(
	parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
	parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF,
	parameter int IDX_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   head_valid,
	input  logic signed [VALUE_WIDTH-1:0]          head_value,
	input  logic [IDX_W-1:0]                       head_col,
	input  tmps_pkg::item_flags_t                  head_flags,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tmps_pkg::OUT_WIDTH-1:0]  max_sum
);

	localparam int SUM_RAW = VALUE_WIDTH + IDX_W + 1;
	localparam int SUM_W   = (SUM_RAW > tmps_pkg::OUT_WIDTH) ? SUM_RAW : tmps_pkg::OUT_WIDTH;

	// Row buffer of best partial sums, one entry per column.
	logic signed [SUM_W-1:0] best_row_q [MAX_ROWS];

	logic                         valid_s1;
	logic signed [VALUE_WIDTH-1:0] value_s1;
	logic [IDX_W-1:0]             col_s1;
	tmps_pkg::item_flags_t        flags_s1;
	logic signed [SUM_W-1:0]      rdata_s1;
	logic                         fwd_s1;
	logic signed [SUM_W-1:0]      fwd_data_s1;

	logic signed [SUM_W-1:0]      left_q;
	logic signed [SUM_W-1:0]      last_max_q;
	logic                         out_valid_q;
	logic signed [tmps_pkg::OUT_WIDTH-1:0] max_sum_q;

	logic signed [SUM_W-1:0]      up;
	logic signed [SUM_W-1:0]      value_ext;
	logic signed [SUM_W-1:0]      best_prev;
	logic signed [SUM_W-1:0]      here;
	logic signed [SUM_W-1:0]      last_max_next;
	logic                         emit;
	logic                         out_free;
	logic                         adv;

	// The sum above comes from the row buffer, or straight from the entry
	// that wrote the same column on the edge the read was made.
	assign up        = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign value_ext = {{(SUM_W - VALUE_WIDTH){value_s1[VALUE_WIDTH-1]}}, value_s1};

	// Best predecessor among the neighbors that exist.
	always_comb begin
		if (flags_s1.has_up && flags_s1.has_left) begin
			best_prev = (up > left_q) ? up : left_q;
		end else if (flags_s1.has_up) begin
			best_prev = up;
		end else if (flags_s1.has_left) begin
			best_prev = left_q;
		end else begin
			best_prev = '0;
		end
	end

	assign here = value_ext + best_prev;

	// Running maximum over the bottom row.
	always_comb begin
		if (!flags_s1.last_row) begin
			last_max_next = last_max_q;
		end else if (col_s1 == '0) begin
			last_max_next = here;
		end else begin
			last_max_next = (here > last_max_q) ? here : last_max_q;
		end
	end

	// Stage flow: a finishing entry waits while a held result is stalled.
	assign emit     = valid_s1 && flags_s1.end_row && flags_s1.last_row;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!emit || out_free);
	assign pop      = head_valid && (!valid_s1 || adv);

	// Stage control and the result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= adv && (col_s1 == head_col);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit && adv) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Stage payload, row buffer access and the per-row state.
	always_ff @(posedge clk) begin
		if (pop) begin
			value_s1    <= head_value;
			col_s1      <= head_col;
			flags_s1    <= head_flags;
			rdata_s1    <= best_row_q[head_col];
			fwd_data_s1 <= here;
		end
		if (adv) begin
			best_row_q[col_s1] <= here;
			left_q             <= up;
			last_max_q         <= last_max_next;
		end
		if (emit && adv) begin
			max_sum_q <= last_max_next[tmps_pkg::OUT_WIDTH-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign max_sum   = max_sum_q;

endmodule

// ===== rtl/triangle_max_path_sum_top.sv =====
`timescale 1ns / 1ps

// Maximum path sum of a number triangle. Write the row count (1 to MAX_ROWS;
// zero acts as one, larger values as MAX_ROWS) while the block is idle, then
// send the entries one per request in row-major order. After the last entry
// of the bottom row the block returns one request carrying the largest
// top-to-bottom path sum and starts on a new triangle. It takes one entry
// every cycle while in_stall is low; the back part reads the row buffer,
// adds and compares once per entry, so row-buffer read and the add-compare
// after it set the rate. A result follows its last entry through the queue
// and stage register. A register write abandons any triangle in progress.
module triangle_max_path_sum_top #(
	parameter int MAX_ROWS    = tmps_pkg::MAX_ROWS_DEF,
	parameter int VALUE_WIDTH = tmps_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tmps_pkg::ROW_COUNT_W-1:0]       row_count,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [VALUE_WIDTH-1:0]          value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tmps_pkg::OUT_WIDTH-1:0]  max_sum
);

	localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int FLAG_W = $bits(tmps_pkg::item_flags_t);
	localparam int ITEM_W = FLAG_W + IDX_W + VALUE_WIDTH;

	logic                          q_push;
	logic                          q_full;
	logic signed [VALUE_WIDTH-1:0] push_value;
	logic [IDX_W-1:0]              push_col;
	tmps_pkg::item_flags_t         push_flags;
	logic                          q_pop;
	logic                          head_valid;
	logic [ITEM_W-1:0]             head_data;
	logic signed [VALUE_WIDTH-1:0] head_value;
	logic [IDX_W-1:0]              head_col;
	tmps_pkg::item_flags_t         head_flags;

	// Front part: takes entries and classifies them by position.
	tmps_front #(
		.MAX_ROWS    (MAX_ROWS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IDX_W       (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.row_count (row_count),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_value   (push_value),
		.q_col     (push_col),
		.q_flags   (push_flags)
	);

	// Short queue between the two parts.
	tmps_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (tmps_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({push_flags, push_col, push_value}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_value = head_data[VALUE_WIDTH-1:0];
	assign head_col   = head_data[VALUE_WIDTH +: IDX_W];
	assign head_flags = head_data[ITEM_W-1 -: FLAG_W];

	// Back part: row buffer update and bottom-row maximum.
	tmps_back #(
		.MAX_ROWS    (MAX_ROWS),
		.VALUE_WIDTH (VALUE_WIDTH),
		.IDX_W       (IDX_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_value (head_value),
		.head_col   (head_col),
		.head_flags (head_flags),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.max_sum    (max_sum)
	);

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into a full queue");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid)
		else $error("pop from an empty queue");

	// The entry closing a row sits on the diagonal and has nothing above it.
	a_row_end_no_up: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && push_flags.end_row) |-> !push_flags.has_up)
		else $error("row end classified with a sum above");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int ROWS_LIMIT = tmps_pkg::MAX_ROWS_DEF;
	localparam int VAL_W      = tmps_pkg::VALUE_WIDTH_DEF;
	localparam int SUM_W      = tmps_pkg::OUT_WIDTH;
	localparam int RC_W       = tmps_pkg::ROW_COUNT_W;

	typedef logic signed [VAL_W-1:0] entry_t;
	typedef logic signed [SUM_W-1:0] path_sum_t;
	typedef logic signed [23:0]      partial_t;

	// Receiver behavior, changed at random by the result side.
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_e;

	// Tracks the best partial sums of the current row, exactly as the block
	// should, and keeps the path sums that are due from the block in order.
	class path_sum_board;
		logic [RC_W-1:0] rows_cfg;
		partial_t        best_sum[ROWS_LIMIT];
		partial_t        left_sum;
		partial_t        bottom_max;
		int              row_idx;
		int              col_idx;
		path_sum_t       due_sums[$];

		function new();
			rows_cfg = 1;
			foreach (best_sum[i]) best_sum[i] = '0;
			restart();
		endfunction

		function void restart();
			left_sum   = '0;
			bottom_max = '0;
			row_idx    = 0;
			col_idx    = 0;
		endfunction

		// A row count write also drops any triangle in progress.
		function void set_rows(input logic [RC_W-1:0] rc);
			rows_cfg = rc;
			restart();
		endfunction

		function int pending();
			return due_sums.size();
		endfunction

		function void note_entry(input entry_t v);
			int       rows;
			int       r;
			int       c;
			partial_t up_sum;
			partial_t here;
			bit       has_up;
			bit       has_left;
			bit       bottom;
			// Zero rows act as one, counts past the buffer as the buffer depth.
			if (rows_cfg == 0)
				rows = 1;
			else if (rows_cfg > ROWS_LIMIT)
				rows = ROWS_LIMIT;
			else
				rows = rows_cfg;
			r = row_idx;
			c = col_idx;
			has_up   = (c < r);
			has_left = (c > 0);
			up_sum   = has_up ? best_sum[c] : '0;
			if (has_up && has_left)
				here = v + ((up_sum > left_sum) ? up_sum : left_sum);
			else if (has_up)
				here = v + up_sum;
			else if (has_left)
				here = v + left_sum;
			else
				here = v;
			left_sum    = up_sum;
			best_sum[c] = here;
			bottom = (r + 1 >= rows);
			if (bottom && (c == 0 || here > bottom_max))
				bottom_max = here;
			// The entry closing a row either ends the triangle or opens the next row.
			if (c >= r) begin
				if (bottom) begin
					due_sums.push_back(bottom_max[SUM_W-1:0]);
					restart();
				end else begin
					row_idx  = r + 1;
					col_idx  = 0;
					left_sum = '0;
				end
			end else begin
				col_idx = c + 1;
			end
		endfunction

		// Returns 0 and a description when the result does not match.
		function bit check_sum(input path_sum_t got, output string why);
			path_sum_t want;
			why = "";
			if (due_sums.size() == 0) begin
				why = $sformatf("max_sum %0d arrived with no triangle finished", got);
				return 0;
			end
			want = due_sums.pop_front();
			if (got !== want) begin
				why = $sformatf("max_sum %0d, predicted %0d", got, want);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [RC_W-1:0] row_count;
	logic            in_valid;
	logic            in_stall;
	entry_t          value;
	logic            out_valid;
	logic            out_stall;
	path_sum_t       max_sum;

	path_sum_board board = new();
	int            err_count;
	int            sent_entries;
	int            burst_left;
	int            rx_cyc;
	stall_mode_e   rx_mode;
	string         sum_note;

	triangle_max_path_sum_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.row_count (row_count),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_sum   (max_sum)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string why);
		err_count++;
		if (err_count <= 40)
			$display("%0t ns mismatch: %s", $time, why);
	endtask

	// Sends one entry. Called just after a rising edge; returns at the edge
	// that takes the request, with valid left high for a back-to-back entry.
	task automatic send_entry(input entry_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		board.note_entry(v);
		sent_entries++;
	endtask

	// Waits until the block has gone quiet, then writes the row count.
	task automatic write_rows(input logic [RC_W-1:0] rc);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		row_count <= rc;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_rows(rc);
	endtask

	// Mix of extremes, small numbers and full-range values.
	function automatic entry_t pick_value();
		entry_t v;
		case ($urandom_range(0, 9))
			0: v = {1'b0, {(VAL_W-1){1'b1}}};
			1: v = {1'b1, {(VAL_W-1){1'b0}}};
			2, 3: v = entry_t'($urandom_range(0, 20)) - entry_t'(10);
			default: v = entry_t'($urandom);
		endcase
		return v;
	endfunction

	// Result side: check each accepted result and stall on a shifting pattern.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (!board.check_sum(max_sum, sum_note))
				report_mismatch(sum_note);
		end
		rx_cyc++;
		if (rx_cyc % 64 == 0)
			rx_mode = stall_mode_e'($urandom_range(0, 3));
		case (rx_mode)
			RX_FREE:     out_stall <= 1'b0;
			RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
			RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
			RX_PERIODIC: out_stall <= (rx_cyc % 5 != 0);
			default:     out_stall <= 1'b0;
		endcase
	end

	initial begin
		int rc;
		int n_rows;
		int n_tri;
		int entries;
		int pick;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		row_count    = '0;
		in_valid     = 1'b0;
		value        = '0;
		out_stall    = 1'b0;
		err_count    = 0;
		sent_entries = 0;
		burst_left   = 0;
		rx_cyc       = 0;
		rx_mode      = RX_FREE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-row triangles at the reset row count: each entry is its own sum.
		send_entry(16'sh7fff);
		send_entry(16'sh8000);
		send_entry(16'sh0000);
		send_entry(16'shffff);

		// Two rows, one path per side, then extremes that alternate in sign.
		write_rows(8'd2);
		send_entry(16'sd1);
		send_entry(16'sd2);
		send_entry(16'sd3);
		send_entry(16'sh8000);
		send_entry(16'sh7fff);
		send_entry(16'sh8000);

		// Three rows, where the best path switches sides.
		write_rows(8'd3);
		send_entry(16'sd5);
		send_entry(-16'sd3);
		send_entry(16'sd7);
		send_entry(16'sd2);
		send_entry(-16'sd100);
		send_entry(16'sd4);

		// A triangle cut short by a register write; zero rows then act as one.
		send_entry(16'sd9);
		send_entry(16'sd8);
		send_entry(16'sd7);
		write_rows(8'd0);
		send_entry(16'sd10);
		send_entry(-16'sd20);

		// Random triangles, mostly small, some abandoned partway.
		while (sent_entries < 700) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				rc = 0;
			else if (pick < 60)
				rc = $urandom_range(1, 4);
			else if (pick < 90)
				rc = $urandom_range(5, 10);
			else
				rc = $urandom_range(11, 24);
			write_rows(rc[RC_W-1:0]);
			n_rows = (rc == 0) ? 1 : rc;
			n_tri  = $urandom_range(1, 5);
			for (int t = 0; t < n_tri; t++) begin
				entries = n_rows * (n_rows + 1) / 2;
				if (t == n_tri - 1 && entries > 1 && $urandom_range(0, 7) == 0)
					entries = $urandom_range(1, entries - 1);
				for (int k = 0; k < entries; k++)
					send_entry(pick_value());
			end
		end

		// A deep triangle of the largest entries, then a count past the buffer
		// depth, which acts as the full depth and never finishes here.
		write_rows(8'd20);
		for (int k = 0; k < 20 * 21 / 2; k++)
			send_entry(16'sh7fff);
		write_rows(8'd255);
		for (int k = 0; k < 40; k++)
			send_entry(16'sh8000);

		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
